>>> design/tac_pkg.sv
// Shared types, constants and helpers of the tile average colour block.
package tac_pkg;

   localparam int unsigned MAX_WIDTH_DEF = 2048;
   localparam int unsigned MAX_TILE_DEF  = 64;
   localparam int unsigned HEIGHT_MAX    = 4096;

   localparam int unsigned POS_W   = 14;
   localparam int unsigned TS_W    = 9;
   localparam int unsigned SUM_W   = 20;
   localparam int unsigned CNT_W   = 17;
   localparam int unsigned REM_W   = CNT_W + 1;
   localparam int unsigned CH_W    = 8;
   localparam int unsigned PIX_W   = 3 * CH_W;
   localparam int unsigned TCOL_W  = 11;
   localparam int unsigned TROW_W  = 12;
   localparam int unsigned RSP_W   = 48;
   localparam int unsigned CIDX_W  = 2;
   localparam int unsigned CDAT_W  = 13;
   localparam int unsigned CFGW_W  = 12;
   localparam int unsigned CFGH_W  = 13;
   localparam int unsigned CFGT_W  = 7;

   localparam logic [CIDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_TILE_SIZE    = 2'd2;

   typedef struct packed {
      logic [TCOL_W-1:0] tile_col;
      logic [TROW_W-1:0] tile_row;
      logic [SUM_W-1:0]  sum_red;
      logic [SUM_W-1:0]  sum_green;
      logic [SUM_W-1:0]  sum_blue;
      logic [CNT_W-1:0]  count;
      logic              frame_done;
   } tile_job_type;

   // One restoring division step: returns {remainder, quotient}.
   function automatic logic [REM_W+SUM_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                      input logic [SUM_W-1:0] quo,
                                                      input logic [CNT_W-1:0] divisor);
      logic [REM_W-1:0] rem_sh;
      logic [SUM_W-1:0] quo_sh;
      rem_sh = {rem[REM_W-2:0], quo[SUM_W-1]};
      quo_sh = {quo[SUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, divisor}) begin
         rem_sh = rem_sh - {1'b0, divisor};
         quo_sh[0] = 1'b1;
      end
      return {rem_sh, quo_sh};
   endfunction

endpackage

>>> design/tac_ram.sv
// Generic single-port-write, registered-read RAM.
module tac_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/tac_front.sv
// Front end: raster position tracking, per-column sum update and tile job issue.
module tac_front #(
   parameter int unsigned MAX_WIDTH = tac_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_TILE  = tac_pkg::MAX_TILE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tac_pkg::PIX_W-1:0]   req_tdata,
   input  logic                        csr_valid,
   input  logic [tac_pkg::CIDX_W-1:0]  csr_index,
   input  logic [tac_pkg::CDAT_W-1:0]  csr_data,
   input  logic                        queue_full,
   output logic                        job_push,
   output tac_pkg::tile_job_type       job
);
   import tac_pkg::*;

   localparam int unsigned AW = $clog2(MAX_WIDTH);

   logic [CFGW_W-1:0] width_ff;
   logic [CFGH_W-1:0] height_ff;
   logic [CFGT_W-1:0] tile_ff;
   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0]  x0_ff, x0_in, y0_ff, y0_in;
   logic [POS_W-1:0]  tc_ff, tc_in, tr_ff, tr_in;
   logic [TS_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic              busy_ff;
   logic [PIX_W-1:0]  pix_ff;

   logic [POS_W-1:0]  w_eff, h_eff, nw_full, nh_full;
   logic [TS_W-1:0]   ts_eff, nw, nh;
   logic [2*TS_W-1:0] area;
   logic              last_col, last_row, start, emit, accept, restart;
   logic [3*SUM_W-1:0] rd_sums, wr_sums;
   logic [SUM_W-1:0]  sr, sg, sb;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = POS_W'(1);
      end else if (POS_W'(width_ff) > POS_W'(MAX_WIDTH)) begin
         w_eff = POS_W'(MAX_WIDTH);
      end else begin
         w_eff = POS_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = POS_W'(1);
      end else if (POS_W'(height_ff) > POS_W'(HEIGHT_MAX)) begin
         h_eff = POS_W'(HEIGHT_MAX);
      end else begin
         h_eff = POS_W'(height_ff);
      end
      if (tile_ff == '0) begin
         ts_eff = TS_W'(1);
      end else if (TS_W'(tile_ff) > TS_W'(MAX_TILE)) begin
         ts_eff = TS_W'(MAX_TILE);
      end else begin
         ts_eff = TS_W'(tile_ff);
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff && !queue_full;
   assign restart    = csr_valid
                    && (csr_index inside {CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_TILE_SIZE});
   assign last_col   = (col_ff == w_eff - POS_W'(1));
   assign last_row   = (row_ff == h_eff - POS_W'(1));
   assign start      = (cx_ff == '0) && (cy_ff == '0);
   assign emit       = ((cx_ff == ts_eff - TS_W'(1)) || last_col)
                    && ((cy_ff == ts_eff - TS_W'(1)) || last_row);

   tac_ram #(.WIDTH(3 * SUM_W), .DEPTH(MAX_WIDTH)) u_sums (
      .clock   (clock),
      .wr_en   (busy_ff),
      .wr_addr (tc_ff[AW-1:0]),
      .wr_data (wr_sums),
      .rd_addr (tc_ff[AW-1:0]),
      .rd_data (rd_sums)
   );

   always_comb begin
      if (start) begin
         sr = SUM_W'(pix_ff[CH_W-1:0]);
         sg = SUM_W'(pix_ff[2*CH_W-1:CH_W]);
         sb = SUM_W'(pix_ff[3*CH_W-1:2*CH_W]);
      end else begin
         sr = rd_sums[SUM_W-1:0] + SUM_W'(pix_ff[CH_W-1:0]);
         sg = rd_sums[2*SUM_W-1:SUM_W] + SUM_W'(pix_ff[2*CH_W-1:CH_W]);
         sb = rd_sums[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_ff[3*CH_W-1:2*CH_W]);
      end
      wr_sums = {sb, sg, sr};

      nw_full = w_eff - x0_ff;
      nh_full = h_eff - y0_ff;
      nw = (nw_full > POS_W'(ts_eff)) ? ts_eff : nw_full[TS_W-1:0];
      nh = (nh_full > POS_W'(ts_eff)) ? ts_eff : nh_full[TS_W-1:0];
      area = nw * nh;

      job.tile_col   = tc_ff[TCOL_W-1:0];
      job.tile_row   = tr_ff[TROW_W-1:0];
      job.sum_red    = sr;
      job.sum_green  = sg;
      job.sum_blue   = sb;
      job.count      = area[CNT_W-1:0];
      job.frame_done = last_col && last_row;
      job_push       = busy_ff && emit;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      x0_in  = x0_ff;
      y0_in  = y0_ff;
      tc_in  = tc_ff;
      tr_in  = tr_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      if (busy_ff) begin
         if (last_col) begin
            col_in = '0;
            x0_in  = '0;
            tc_in  = '0;
            cx_in  = '0;
            if (last_row) begin
               row_in = '0;
               y0_in  = '0;
               tr_in  = '0;
               cy_in  = '0;
            end else begin
               row_in = row_ff + POS_W'(1);
               if (cy_ff == ts_eff - TS_W'(1)) begin
                  cy_in = '0;
                  tr_in = tr_ff + POS_W'(1);
                  y0_in = y0_ff + POS_W'(ts_eff);
               end else begin
                  cy_in = cy_ff + TS_W'(1);
               end
            end
         end else begin
            col_in = col_ff + POS_W'(1);
            if (cx_ff == ts_eff - TS_W'(1)) begin
               cx_in = '0;
               tc_in = tc_ff + POS_W'(1);
               x0_in = x0_ff + POS_W'(ts_eff);
            end else begin
               cx_in = cx_ff + TS_W'(1);
            end
         end
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
         x0_in  = '0;
         y0_in  = '0;
         tc_in  = '0;
         tr_in  = '0;
         cx_in  = '0;
         cy_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFGW_W'(640);
         height_ff <= CFGH_W'(480);
         tile_ff   <= CFGT_W'(8);
         busy_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         x0_ff     <= '0;
         y0_ff     <= '0;
         tc_ff     <= '0;
         tr_ff     <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else begin
         busy_ff <= accept;
         col_ff  <= col_in;
         row_ff  <= row_in;
         x0_ff   <= x0_in;
         y0_ff   <= y0_in;
         tc_ff   <= tc_in;
         tr_ff   <= tr_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_data[CFGW_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_data[CFGH_W-1:0];
               CSR_TILE_SIZE:    tile_ff   <= csr_data[CFGT_W-1:0];
               default: ;
            endcase
         end
      end
      if (accept) begin
         pix_ff <= req_tdata;
      end
   end
endmodule

>>> design/tac_queue.sv
// Two-entry job queue between the front end and the divider back end.
module tac_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tac_pkg::tile_job_type push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output tac_pkg::tile_job_type pop_job
);
   import tac_pkg::*;

   tile_job_type entries_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_job   = entries_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         entries_ff[wp_ff] <= push_job;
      end
   end
endmodule

>>> design/tac_back.sv
// Back end: iterative division of the three tile sums and the result register.
module tac_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  tac_pkg::tile_job_type      job,
   output logic                       job_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tac_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);
   import tac_pkg::*;

   typedef enum logic [1:0] {IDLE, DIVIDE, DELIVER} state_type;

   localparam int unsigned STEP_W = $clog2(SUM_W);

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [REM_W-1:0]  rem_r_ff, rem_g_ff, rem_b_ff;
   logic [SUM_W-1:0]  quo_r_ff, quo_g_ff, quo_b_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [TCOL_W-1:0] tc_ff;
   logic [TROW_W-1:0] tr_ff;
   logic              done_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              rsp_last_ff;
   logic [REM_W+SUM_W-1:0] nx_r, nx_g, nx_b;

   assign nx_r       = div_step(rem_r_ff, quo_r_ff, div_ff);
   assign nx_g       = div_step(rem_g_ff, quo_g_ff, div_ff);
   assign nx_b       = div_step(rem_b_ff, quo_b_ff, div_ff);
   assign job_pop    = (state_ff == IDLE) && job_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  rem_r_ff <= '0;
                  rem_g_ff <= '0;
                  rem_b_ff <= '0;
                  quo_r_ff <= job.sum_red;
                  quo_g_ff <= job.sum_green;
                  quo_b_ff <= job.sum_blue;
                  div_ff   <= job.count;
                  tc_ff    <= job.tile_col;
                  tr_ff    <= job.tile_row;
                  done_ff  <= job.frame_done;
                  step_ff  <= '0;
                  state_ff <= DIVIDE;
               end
            end
            DIVIDE: begin
               {rem_r_ff, quo_r_ff} <= nx_r;
               {rem_g_ff, quo_g_ff} <= nx_g;
               {rem_b_ff, quo_b_ff} <= nx_b;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  state_ff <= DELIVER;
               end
            end
            DELIVER: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, quo_b_ff[CH_W-1:0], quo_g_ff[CH_W-1:0],
                                   quo_r_ff[CH_W-1:0], tr_ff, tc_ff};
                  rsp_last_ff  <= done_ff;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

>>> design/tile_average_colour_core.sv
// Top level of the tile average colour block.
// Each pixel beat reads the running sums of its tile column from the column sum
// memory and then writes them back; no new beat is taken during the write-back.
// A finished tile goes through a two-entry queue to a shared restoring divider
// that loads it, runs 20 quotient steps and hands off the result. Tiles finish
// one tile width apart along the bottom row of a tile row, so tiles at least
// 11 pixels wide never stall the pixel stream while results are taken at once.
// Any write to a defined register restarts the frame at its top-left pixel;
// out-of-range register values are saturated (zero acts as one).
module tile_average_colour_core #(
   parameter int unsigned MAX_WIDTH = tac_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_TILE  = tac_pkg::MAX_TILE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tac_pkg::PIX_W-1:0]  req_tdata,   // red, green, blue
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tac_pkg::RSP_W-1:0]  rsp_tdata,   // tile_col, tile_row, avg_red,
                                                   // avg_green, avg_blue, zero pad
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tac_pkg::CIDX_W-1:0] csr_index,
   input  logic [tac_pkg::CDAT_W-1:0] csr_data
);
   import tac_pkg::*;

   tile_job_type push_job, pop_job;
   logic         push, pop, full, not_empty;

   assign csr_ready = 1'b1;

   tac_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_TILE(MAX_TILE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (full),
      .job_push   (push),
      .job        (push_job)
   );

   tac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_job   (pop_job)
   );

   tac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (not_empty),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

>>> design/tac_checker.sv
// Port-level assertions for the tile average colour block, bound to the top level.
module tac_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [tac_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                       rsp_tlast
);
   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Each pixel beat occupies the sum memory during its write-back, when no pixel is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel accepted during sum write-back");

   // No result is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind tile_average_colour_core tac_checker u_tac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> verif/testbench.sv
// Self-checking testbench for tile_average_colour_core: tile averages are checked against a local model.
`timescale 1ns / 1ps

module testbench;
   import tac_pkg::*;

   typedef struct packed {
      logic [10:0] tile_col;
      logic [11:0] tile_row;
      logic [7:0]  avg_red;
      logic [7:0]  avg_green;
      logic [7:0]  avg_blue;
      logic        frame_done;
   } tile_avg_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [CIDX_W-1:0] index;
      logic [CDAT_W-1:0] value;
      logic [PIX_W-1:0]  pixel;
      bit                typed;
      tile_avg_type      tile;
   } stim_row_type;

   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned STALL_LIMIT   = 2000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PIX_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CIDX_W-1:0]   csr_index = '0;
   logic [CDAT_W-1:0]   csr_data = '0;

   tile_avg_type tiles_due[$];
   stim_row_type stim_rows[$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   bit          quiet = 1'b0;
   int unsigned rsp_hold = 0;

   logic [11:0] width_reg;
   logic [12:0] height_reg;
   logic [6:0]  tile_reg;
   int unsigned next_col;
   int unsigned next_row;
   logic [19:0] red_acc[MAX_WIDTH_DEF];
   logic [19:0] green_acc[MAX_WIDTH_DEF];
   logic [19:0] blue_acc[MAX_WIDTH_DEF];

   tile_average_colour_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned saturate(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void apply_csr(logic [CIDX_W-1:0] index, logic [CDAT_W-1:0] value);
      case (index)
         CSR_IMAGE_WIDTH: width_reg = value[11:0];
         CSR_IMAGE_HEIGHT: height_reg = value;
         CSR_TILE_SIZE: tile_reg = value[6:0];
         default: return;
      endcase
      next_col = 0;
      next_row = 0;
   endfunction

   function automatic bit average_pixel(logic [PIX_W-1:0] pixel, output tile_avg_type tile);
      int unsigned w, h, ts, col, row, tc, tr, cx, cy, nw, nh, cnt;
      bit first, last_col, last_row, emit;
      w = saturate(width_reg, MAX_WIDTH_DEF);
      h = saturate(height_reg, HEIGHT_MAX);
      ts = saturate(tile_reg, MAX_TILE_DEF);
      col = (next_col >= w) ? w - 1 : next_col;
      row = (next_row >= h) ? h - 1 : next_row;
      tc = (col / ts) & (MAX_WIDTH_DEF - 1);
      tr = row / ts;
      cx = col % ts;
      cy = row % ts;
      first = (cx == 0 && cy == 0);
      red_acc[tc] = first ? 20'(pixel[7:0]) : red_acc[tc] + pixel[7:0];
      green_acc[tc] = first ? 20'(pixel[15:8]) : green_acc[tc] + pixel[15:8];
      blue_acc[tc] = first ? 20'(pixel[23:16]) : blue_acc[tc] + pixel[23:16];
      last_col = (col == w - 1);
      last_row = (row == h - 1);
      emit = (cx == ts - 1 || last_col) && (cy == ts - 1 || last_row);
      tile = '0;
      if (emit) begin
         nw = (w - tc * ts > ts) ? ts : w - tc * ts;
         nh = (h - tr * ts > ts) ? ts : h - tr * ts;
         cnt = (nw * nh == 0) ? 1 : nw * nh;
         tile.tile_col = tc[10:0];
         tile.tile_row = tr[11:0];
         tile.avg_red = 8'(red_acc[tc] / cnt);
         tile.avg_green = 8'(green_acc[tc] / cnt);
         tile.avg_blue = 8'(blue_acc[tc] / cnt);
         tile.frame_done = last_col && last_row;
      end
      if (last_col) begin
         next_col = 0;
         next_row = last_row ? 0 : ((row + 1) & 12'hFFF);
      end else begin
         next_col = (col + 1) & 11'h7FF;
         next_row = row;
      end
      return emit;
   endfunction

   task automatic report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic add_csr(logic [CIDX_W-1:0] index, logic [CDAT_W-1:0] value);
      stim_row_type r;
      r = '{kind: ROW_CSR, default: '0};
      r.index = index;
      r.value = value;
      stim_rows.push_back(r);
   endtask

   task automatic add_pixel(logic [PIX_W-1:0] pixel, bit typed, tile_avg_type tile);
      stim_row_type r;
      r = '{kind: ROW_PIXEL, default: '0};
      r.pixel = pixel;
      r.typed = typed;
      r.tile = tile;
      stim_rows.push_back(r);
   endtask

   task automatic settle();
      wait (tiles_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CIDX_W-1:0] index, logic [CDAT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] pixel, bit typed, tile_avg_type tile);
      tile_avg_type predicted;
      bit emit;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= pixel;
      do @(posedge clock); while (!req_tready);
      emit = average_pixel(pixel, predicted);
      if (typed) tiles_due.push_back(tile);
      else if (emit) tiles_due.push_back(predicted);
   endtask

   task automatic stop_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic run_frame(int unsigned w, int unsigned h, int unsigned ts, int unsigned pixels);
      tile_avg_type none;
      none = '0;
      settle();
      write_csr(CSR_TILE_SIZE, CDAT_W'(ts));
      write_csr(CSR_IMAGE_HEIGHT, CDAT_W'(h));
      write_csr(CSR_IMAGE_WIDTH, CDAT_W'(w));
      repeat (pixels) send_pixel(random_pixel(), 1'b0, none);
      stop_pixels();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         rsp_hold <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tile_avg_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[10:0], rsp_tdata[22:11], rsp_tdata[30:23], rsp_tdata[38:31],
                rsp_tdata[46:39], rsp_tlast};
         if (tiles_due.size() == 0) begin
            report("unexpected tile_col", got.tile_col, 0);
         end else begin
            want = tiles_due.pop_front();
            if (got.tile_col !== want.tile_col) report("tile_col", got.tile_col, want.tile_col);
            if (got.tile_row !== want.tile_row) report("tile_row", got.tile_row, want.tile_row);
            if (got.avg_red !== want.avg_red) report("avg_red", got.avg_red, want.avg_red);
            if (got.avg_green !== want.avg_green)
               report("avg_green", got.avg_green, want.avg_green);
            if (got.avg_blue !== want.avg_blue) report("avg_blue", got.avg_blue, want.avg_blue);
            if (got.frame_done !== want.frame_done)
               report("frame_done", got.frame_done, want.frame_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tile_average_colour_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned sent;
      int unsigned w, h, ts, frame;
      tile_avg_type t;
      width_reg = 12'd640;
      height_reg = 13'd480;
      tile_reg = 7'd8;
      next_col = 0;
      next_row = 0;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         red_acc[i] = '0;
         green_acc[i] = '0;
         blue_acc[i] = '0;
      end

      // A zero in every register acts as one, so each pixel is a finished tile.
      add_csr(CSR_IMAGE_WIDTH, '0);
      add_csr(CSR_IMAGE_HEIGHT, '0);
      add_csr(CSR_TILE_SIZE, '0);
      add_pixel(24'h000000, 1'b1, '{11'd0, 12'd0, 8'h00, 8'h00, 8'h00, 1'b1});
      add_pixel(24'hFFFFFF, 1'b1, '{11'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1});
      add_pixel(24'h0000FF, 1'b1, '{11'd0, 12'd0, 8'hFF, 8'h00, 8'h00, 1'b1});
      add_pixel(24'h00FF00, 1'b1, '{11'd0, 12'd0, 8'h00, 8'hFF, 8'h00, 1'b1});
      add_pixel(24'hFF0000, 1'b1, '{11'd0, 12'd0, 8'h00, 8'h00, 8'hFF, 1'b1});
      add_pixel(24'hAA55AA, 1'b1, '{11'd0, 12'd0, 8'hAA, 8'h55, 8'hAA, 1'b1});
      // Index three names no register and leaves the frame alone.
      add_csr(2'd3, '1);
      add_pixel(24'h55AA55, 1'b1, '{11'd0, 12'd0, 8'h55, 8'hAA, 8'h55, 1'b1});
      add_csr(CSR_IMAGE_WIDTH, 13'd2);
      add_csr(CSR_IMAGE_HEIGHT, 13'd3);
      add_csr(CSR_TILE_SIZE, 13'd2);
      t = '0;
      add_pixel(24'hFF00FF, 1'b0, t);
      add_pixel(24'hFE01FE, 1'b0, t);
      add_pixel(24'hFFFF00, 1'b0, t);
      add_pixel(24'h010000, 1'b0, t);
      add_pixel(24'h123456, 1'b0, t);
      add_pixel(24'hFFFFFF, 1'b0, t);
      add_csr(CSR_IMAGE_WIDTH, 13'd3);
      add_csr(CSR_IMAGE_HEIGHT, 13'd1);
      add_pixel(24'h808080, 1'b0, t);
      add_pixel(24'h7F7F7F, 1'b0, t);
      add_pixel(24'hFFFFFF, 1'b0, t);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            stop_pixels();
            settle();
            write_csr(stim_rows[i].index, stim_rows[i].value);
         end else begin
            send_pixel(stim_rows[i].pixel, stim_rows[i].typed, stim_rows[i].tile);
         end
      end
      stop_pixels();

      // Saturating register values and the largest tile.
      run_frame(4095, 1, 127, 200);
      run_frame(130, 3, 64, 390);
      run_frame(1, 8191, 127, 150);
      run_frame(2048, 4096, 64, 100);

      sent = 0;
      while (sent < 350) begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 8);
         ts = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 9);
         frame = w * h;
         frame = frame + $urandom_range(0, frame);
         if (sent > 250) quiet = 1'b1;
         run_frame(w, h, ts, frame);
         sent += frame;
      end

      settle();
      if (mismatches == 0) begin
         $display("tile_average_colour_core test passed");
      end else begin
         $display("tile_average_colour_core test failed");
      end
      $finish;
   end

endmodule
